/* src/serial_loaded_rom_bank_mapper_unit_macros.svh */
// assertion macros for the bank mapper
`ifndef SERIAL_LOADED_ROM_BANK_MAPPER_UNIT_MACROS_SVH
`define SERIAL_LOADED_ROM_BANK_MAPPER_UNIT_MACROS_SVH

// clocked assertion, switched off during reset
`define SLRBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SLRBM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/slrbm_pkg.sv */
// types and constants shared by the bank mapper files
package slrbm_pkg;

  localparam int PRG_ADDR_WIDTH = 20;

  localparam logic [6:0] PRG_COUNT_RESET  = 7'd8;
  localparam logic [5:0] CHR_COUNT_RESET  = 6'd16;
  localparam logic [1:0] BOOT_MIRROR_RESET = 2'd2;
  localparam logic [4:0] CONTROL_RESET    = 5'h0C;

  localparam logic [1:0] MIRROR_ONE_SCREEN = 2'd0;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;

  localparam logic [1:0] REG_PRG_PAGES  = 2'd0;
  localparam logic [1:0] REG_CHR_PAGES  = 2'd1;
  localparam logic [1:0] REG_LARGE_ROM  = 2'd2;
  localparam logic [1:0] REG_BOOT_MIRROR = 2'd3;

  localparam logic [1:0] SEL_CONTROL  = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
  localparam logic [1:0] SEL_PRG      = 2'd3;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam int CFG_DATA_WIDTH = 7;

  typedef struct packed {
    logic        cmd;
    logic [15:0] cpu_addr;
    logic [7:0]  wdata;
  } req_item_t;

  typedef struct packed {
    logic [PRG_ADDR_WIDTH-1:0] prg_rom_addr;
    logic [1:0]                mirroring;
    logic [4:0]                chr_window_low;
    logic [4:0]                chr_window_high;
  } rsp_item_t;

endpackage

/* src/slrbm_if.sv */
// valid/ready channels carrying bus accesses and mapping results
interface slrbm_req_if;
  import slrbm_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface slrbm_rsp_if;
  import slrbm_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* src/serial_loaded_rom_bank_mapper_unit.sv */
// serially loaded cartridge bank mapper with a shared restoring subtractor
// a transaction passes through ST_FIN, which registers its result; a write that loads the prg bank
// first runs the prg bank modulo in ST_MOD, one quotient bit a cycle on one subtractor
// one transaction at a time: the bus is ready only in ST_IDLE
// a waiting result does not block accepting the next transaction; its result then waits in ST_FIN
// reset: synchronous, clears the sequencer, restores register and banking defaults
`include "serial_loaded_rom_bank_mapper_unit_macros.svh"

module serial_loaded_rom_bank_mapper_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [slrbm_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  slrbm_req_if.sink                              bus,
  slrbm_rsp_if.source                            result
);
  import slrbm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_FIN} state_t;

  state_t      state;
  logic [6:0]  prg_page_count;
  logic [5:0]  chr_page_count;
  logic        large_rom_enable;
  logic [1:0]  boot_mirroring;

  logic [4:0]  shift_value;
  logic [2:0]  shift_count;
  logic [4:0]  control_bits;
  logic [4:0]  prg_bank;
  logic        outer_bank_bit;
  logic [1:0]  mirror_state;
  logic [4:0]  chr_low_page;
  logic [4:0]  chr_high_page;

  logic        held_cmd;
  logic [15:0] held_addr;
  logic [4:0]  dividend;
  logic [7:0]  rem;
  logic [2:0]  step;

  logic        out_valid;
  rsp_item_t   out_item;

  logic        accept;
  logic [4:0]  shift_next;
  logic [4:0]  page;
  logic [5:0]  page_plus;
  logic [6:0]  eff_count;
  logic [7:0]  rem_shift;
  logic [7:0]  rem_next;
  logic [PRG_ADDR_WIDTH-1:0] prg_addr;
  logic [19:0] large_off;
  logic [3:0]  last_page;

  assign accept     = bus.valid && bus.ready;
  assign bus.ready  = (state == ST_IDLE);
  assign shift_next = {bus.payload.wdata[0], shift_value[4:1]};
  assign page       = shift_next;
  assign page_plus  = {1'b0, page} + 6'd1;
  assign eff_count  = (prg_page_count == 7'd0) ? 7'd1 : prg_page_count;

  // shared restoring subtractor
  assign rem_shift = {rem[6:0], dividend[step]};
  assign rem_next  = (rem_shift >= {1'b0, eff_count}) ? rem_shift - {1'b0, eff_count}
                                                      : rem_shift;

  // program address for the held read
  always_comb begin
    large_off = {1'b0, (outer_bank_bit & large_rom_enable), 18'd0};
    last_page = prg_page_count[3:0] - 4'd1;
    prg_addr  = '0;
    if (held_cmd == CMD_READ) begin
      if (control_bits[3]) begin
        if (held_addr[14] ^ control_bits[2]) begin
          prg_addr = PRG_ADDR_WIDTH'({1'b0, prg_bank, 14'd0} + large_off
                                     + {6'd0, held_addr[13:0]});
        end else if (control_bits[2]) begin
          prg_addr = PRG_ADDR_WIDTH'({2'd0, last_page, 14'd0} + large_off
                                     + {6'd0, held_addr[13:0]});
        end else begin
          prg_addr = PRG_ADDR_WIDTH'(large_off + {6'd0, held_addr[13:0]});
        end
      end else begin
        prg_addr = PRG_ADDR_WIDTH'({1'b0, prg_bank[4:1], 15'd0} + large_off
                                   + {5'd0, held_addr[14:0]});
      end
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      prg_page_count   <= PRG_COUNT_RESET;
      chr_page_count   <= CHR_COUNT_RESET;
      large_rom_enable <= 1'b0;
      boot_mirroring   <= BOOT_MIRROR_RESET;
      shift_value      <= '0;
      shift_count      <= '0;
      control_bits     <= CONTROL_RESET;
      prg_bank         <= '0;
      outer_bank_bit   <= 1'b0;
      mirror_state     <= BOOT_MIRROR_RESET;
      chr_low_page     <= '0;
      chr_high_page    <= 5'd1;
      out_valid        <= 1'b0;
      step             <= '0;
    end else begin
      if (out_valid && result.ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PRG_PAGES: prg_page_count <= cfg_data[6:0];
          REG_CHR_PAGES: chr_page_count <= cfg_data[5:0];
          REG_LARGE_ROM: large_rom_enable <= cfg_data[0];
          REG_BOOT_MIRROR: begin
            boot_mirroring <= cfg_data[1:0];
            mirror_state   <= (cfg_data[1:0] == 2'd3) ? MIRROR_VERTICAL : cfg_data[1:0];
          end
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            held_cmd  <= bus.payload.cmd;
            held_addr <= bus.payload.cpu_addr;
            state     <= ST_FIN;
            if (bus.payload.cmd == CMD_WRITE) begin
              if (bus.payload.wdata[7]) begin
                control_bits <= {control_bits[4], 4'hC};
                shift_value  <= '0;
                shift_count  <= '0;
              end else if (shift_count == 3'd4) begin
                shift_value <= '0;
                shift_count <= '0;
                unique case (bus.payload.cpu_addr[14:13])
                  SEL_CONTROL: begin
                    control_bits <= page;
                    if (!page[1]) mirror_state <= MIRROR_ONE_SCREEN;
                    else mirror_state <= page[0] ? MIRROR_HORIZONTAL : MIRROR_VERTICAL;
                  end
                  SEL_CHR_LOW: begin
                    outer_bank_bit <= page[4];
                    if ({1'b0, page} < chr_page_count) begin
                      chr_low_page <= page;
                      if (!control_bits[4] && page_plus < chr_page_count) begin
                        chr_high_page <= page_plus[4:0];
                      end
                    end
                  end
                  SEL_CHR_HIGH: begin
                    if ({1'b0, page} < chr_page_count && control_bits[4]) begin
                      chr_high_page <= page;
                    end
                  end
                  SEL_PRG: begin
                    dividend <= control_bits[3] ? page : {page[4:1], 1'b0};
                    rem      <= '0;
                    step     <= 3'd4;
                    state    <= ST_MOD;
                  end
                  default: ;
                endcase
              end else begin
                shift_value <= shift_next;
                shift_count <= shift_count + 3'd1;
              end
            end
          end
        end
        ST_MOD: begin
          rem <= rem_next;
          if (step == 3'd0) begin
            prg_bank <= rem_next[4:0];
            state    <= ST_FIN;
          end else begin
            step <= step - 3'd1;
          end
        end
        ST_FIN: begin
          if (!out_valid || result.ready) begin
            out_valid                <= 1'b1;
            out_item.prg_rom_addr    <= prg_addr;
            out_item.mirroring       <= mirror_state;
            out_item.chr_window_low  <= chr_low_page;
            out_item.chr_window_high <= chr_high_page;
            state                    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SLRBM_ASSERT(a_busy_after_accept, accept |=> !bus.ready, "sequencer idle after accept")
  `SLRBM_ASSERT(a_shift_count_range, shift_count < 3'd5, "serial shifter count above four")
  `SLRBM_ASSERT(a_result_fin, $rose(result.valid) |-> $past(state) == ST_FIN, "stray result")
  `SLRBM_ASSERT(a_mod_step_range, (state == ST_MOD) |-> step < 3'd5, "modulo step out of range")
  `SLRBM_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !result.valid, "result after reset")

endmodule
